FILE: sv/rsdq_pkg.sv
// Shared types, constants and the ring slot function for the record sort/dequeue core.
`default_nettype none
package rsdq_pkg;

  // Table geometry
  localparam int MAX_RECORDS = 64;
  localparam int SLOT_W      = $clog2(MAX_RECORDS);
  localparam int CNT_W       = $clog2(MAX_RECORDS + 1);

  // Field widths
  localparam int REQ_W    = 2;
  localparam int ID_W     = 16;
  localparam int TIME_W   = 31;
  localparam int STATUS_W = 2;
  localparam int REM_W    = 7;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_APPEND = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SORT   = 2'd2;
  localparam logic [REQ_W-1:0] REQ_POP    = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [ID_W-1:0]   proc_id;
    logic [TIME_W-1:0] arrival_time;
    logic [TIME_W-1:0] burst_time;
  } req_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     out_proc_id;
    logic [TIME_W-1:0]   out_arrival_time;
    logic [TIME_W-1:0]   out_burst_time;
    logic [REM_W-1:0]    remaining;
  } rsp_word_t;

  // One stored record
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] burst;
  } record_t;

  localparam int REC_W = $bits(record_t);

  // Physical slot of logical position pos in the ring starting at head.
  // head < MAX_RECORDS and pos <= MAX_RECORDS, so one subtract wraps it.
  function automatic logic [SLOT_W-1:0] slot_of(input logic [SLOT_W-1:0] head,
                                                input logic [CNT_W-1:0]  pos);
    logic [CNT_W:0] sum;
    sum = {{(CNT_W + 1 - SLOT_W){1'b0}}, head} + {1'b0, pos};
    if (sum >= (CNT_W + 1)'(MAX_RECORDS)) begin
      sum = sum - (CNT_W + 1)'(MAX_RECORDS);
    end
    return sum[SLOT_W-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: sv/rsdq_ram.sv
// Simple dual-port RAM: one write port, one read port with registered read data.
`default_nettype none
module rsdq_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: sv/record_sort_and_dequeue_core.sv
// Top level: record table with clear, append, stable sort by cpu time and pop.
`default_nettype none
// Holds up to MAX_RECORDS process records in a ring kept in one dual-port
// RAM (one write, one read per cycle, registered read data). Each accepted
// request word yields exactly one response word. Clear and append complete
// in the idle state; pop also passes through a pop state for the RAM read of
// the head record. A sort of n records runs n-1 bubble passes; each pass
// streams one record per cycle through the single read port while the larger
// record rides along in a carry register. Records with equal cpu time keep
// their order. A new request is taken once the previous one has finished and
// the response register is empty or being drained in the same cycle.
module record_sort_and_dequeue_core
  import rsdq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      req_valid,
  output logic           req_stall,
  input  wire req_word_t req,
  output logic           rsp_valid,
  input  wire logic      rsp_stall,
  output rsp_word_t      rsp
);

  localparam logic [2:0] ST_IDLE       = 3'd0;
  localparam logic [2:0] ST_POP        = 3'd1;
  localparam logic [2:0] ST_SORT_FIRST = 3'd2;
  localparam logic [2:0] ST_SORT_RUN   = 3'd3;
  localparam logic [2:0] ST_SORT_LAST  = 3'd4;

  logic [2:0]        state, state_next;
  logic [SLOT_W-1:0] head, head_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [CNT_W-1:0]  pass_len, pass_len_next;
  logic [CNT_W-1:0]  pos, pos_next;
  record_t           carry, carry_next;
  logic              rsp_valid_next;
  rsp_word_t         rsp_next;

  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  logic [REC_W-1:0]  ram_wdata;
  logic [SLOT_W-1:0] ram_raddr;
  logic [REC_W-1:0]  ram_rdata;
  record_t           rd_rec;
  record_t           in_rec;
  logic              take;

  rsdq_ram #(
    .DATA_W (REC_W),
    .DEPTH  (MAX_RECORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Handshake
  assign req_stall = !((state == ST_IDLE) && (!rsp_valid || !rsp_stall));
  assign take      = req_valid && !req_stall;

  assign rd_rec = record_t'(ram_rdata);
  assign in_rec = '{id: req.proc_id, arrival: req.arrival_time, burst: req.burst_time};

  // Request decode, sort sequencer and RAM port steering
  always_comb begin
    state_next     = state;
    head_next      = head;
    count_next     = count;
    pass_len_next  = pass_len;
    pos_next       = pos;
    carry_next     = carry;
    rsp_valid_next = rsp_valid && rsp_stall;
    rsp_next       = rsp;
    ram_we         = 1'b0;
    ram_waddr      = slot_of(head, pos);
    ram_wdata      = carry;
    ram_raddr      = head;

    unique case (state)
      ST_IDLE: begin
        if (take) begin
          rsp_next        = '0;
          rsp_next.status = STATUS_OK;
          case (req.req_type)
            REQ_CLEAR: begin
              count_next     = '0;
              head_next      = '0;
              rsp_valid_next = 1'b1;
            end
            REQ_APPEND: begin
              rsp_valid_next = 1'b1;
              if (count == CNT_W'(MAX_RECORDS)) begin
                rsp_next.status = STATUS_FULL;
              end else begin
                ram_we     = 1'b1;
                ram_waddr  = slot_of(head, count);
                ram_wdata  = in_rec;
                count_next = count + CNT_W'(1);
              end
              rsp_next.remaining = REM_W'(count_next);
            end
            REQ_SORT: begin
              if (count < CNT_W'(2)) begin
                rsp_valid_next     = 1'b1;
                rsp_next.remaining = REM_W'(count);
              end else begin
                pass_len_next = count;
                pos_next      = CNT_W'(1);
                ram_raddr     = head;
                state_next    = ST_SORT_FIRST;
              end
            end
            default: begin
              if (count == '0) begin
                rsp_valid_next     = 1'b1;
                rsp_next.status    = STATUS_EMPTY;
                rsp_next.remaining = '0;
              end else begin
                ram_raddr  = head;
                head_next  = slot_of(head, CNT_W'(1));
                count_next = count - CNT_W'(1);
                state_next = ST_POP;
              end
            end
          endcase
        end
      end

      // Head record is back from the RAM
      ST_POP: begin
        rsp_valid_next            = 1'b1;
        rsp_next.status           = STATUS_OK;
        rsp_next.out_proc_id      = rd_rec.id;
        rsp_next.out_arrival_time = rd_rec.arrival;
        rsp_next.out_burst_time   = rd_rec.burst;
        rsp_next.remaining        = REM_W'(count);
        state_next                = ST_IDLE;
      end

      // First record of a pass goes into the carry
      ST_SORT_FIRST: begin
        carry_next = rd_rec;
        ram_raddr  = slot_of(head, pos);
        state_next = ST_SORT_RUN;
      end

      // Compare carry with record at pos; smaller one lands at pos-1
      ST_SORT_RUN: begin
        ram_we    = 1'b1;
        ram_waddr = slot_of(head, pos - CNT_W'(1));
        if (carry.burst > rd_rec.burst) begin
          ram_wdata = rd_rec;
        end else begin
          ram_wdata  = carry;
          carry_next = rd_rec;
        end
        if ((pos + CNT_W'(1)) < pass_len) begin
          ram_raddr = slot_of(head, pos + CNT_W'(1));
          pos_next  = pos + CNT_W'(1);
        end else begin
          state_next = ST_SORT_LAST;
        end
      end

      // Largest record of the pass settles at the last position
      ST_SORT_LAST: begin
        ram_we    = 1'b1;
        ram_waddr = slot_of(head, pos);
        ram_wdata = carry;
        if (pass_len > CNT_W'(2)) begin
          pass_len_next = pass_len - CNT_W'(1);
          pos_next      = CNT_W'(1);
          ram_raddr     = head;
          state_next    = ST_SORT_FIRST;
        end else begin
          rsp_valid_next     = 1'b1;
          rsp_next           = '0;
          rsp_next.status    = STATUS_OK;
          rsp_next.remaining = REM_W'(count);
          state_next         = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      count     <= count_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    pass_len <= pass_len_next;
    pos      <= pos_next;
    carry    <= carry_next;
    rsp      <= rsp_next;
  end

endmodule
`default_nettype wire

FILE: verif/tb_record_sort_and_dequeue_core.sv
// Testbench for the record sort/dequeue core: queued driver, checking monitor, table predictor.
`default_nettype none
module tb_record_sort_and_dequeue_core
  import rsdq_pkg::*;
();

  localparam int IDLE_LIMIT = 30000;
  localparam int TAIL_CYCLES = 50;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  typedef struct {
    req_word_t word;
    bit        drain;   // hold this word back until all responses are in
  } pending_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  req_word_t req = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  rsp_word_t rsp;

  record_sort_and_dequeue_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  pending_t  pending_words[$];
  rsp_word_t expected_rsps[$];
  int        errors = 0;
  int        checked = 0;
  int        kind_cnt[4];
  int        dropped_cnt = 0;
  int        empty_pop_cnt = 0;
  int        idle_cycles = 0;
  int        cycle_cnt = 0;
  int        send_gap = 0;
  int        stall_left = 0;
  int        plan_cnt = 0;
  logic      calm;

  // Record table shadow
  record_t   shadow_tbl [MAX_RECORDS];
  int        shadow_head = 0;
  int        shadow_cnt = 0;

  // Periodic stretches with no idling on either side
  assign calm = ((cycle_cnt / 300) % 5) == 4;

  function automatic int ring_slot(input int pos);
    return (shadow_head + pos) % MAX_RECORDS;
  endfunction

  // Apply one request to the shadow table and return the response it yields
  function automatic rsp_word_t apply_request(input req_word_t w);
    rsp_word_t r;
    record_t   t;
    int        s, a, b, pass, k;
    r = '0;
    r.status = STATUS_OK;
    case (w.req_type)
      REQ_CLEAR: begin
        shadow_cnt = 0;
        shadow_head = 0;
      end
      REQ_APPEND: begin
        if (shadow_cnt >= MAX_RECORDS) begin
          r.status = STATUS_FULL;
        end else begin
          s = ring_slot(shadow_cnt);
          shadow_tbl[s].id = w.proc_id;
          shadow_tbl[s].arrival = w.arrival_time;
          shadow_tbl[s].burst = w.burst_time;
          shadow_cnt++;
        end
      end
      REQ_SORT: begin
        // stable: swap only on strictly greater cpu time
        for (pass = 0; pass + 1 < shadow_cnt; pass++) begin
          for (k = 0; k + 1 < shadow_cnt - pass; k++) begin
            a = ring_slot(k);
            b = ring_slot(k + 1);
            if (shadow_tbl[a].burst > shadow_tbl[b].burst) begin
              t = shadow_tbl[a];
              shadow_tbl[a] = shadow_tbl[b];
              shadow_tbl[b] = t;
            end
          end
        end
      end
      REQ_POP: begin
        if (shadow_cnt == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          s = ring_slot(0);
          r.out_proc_id = shadow_tbl[s].id;
          r.out_arrival_time = shadow_tbl[s].arrival;
          r.out_burst_time = shadow_tbl[s].burst;
          shadow_head = ring_slot(1);
          shadow_cnt--;
        end
      end
    endcase
    r.remaining = REM_W'(shadow_cnt);
    return r;
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  // Request word with random record fields; keys often collide to exercise stability
  function automatic req_word_t rand_word(input logic [REQ_W-1:0] kind);
    req_word_t w;
    int        r;
    w.req_type = kind;
    w.proc_id = ID_W'($urandom());
    w.arrival_time = TIME_W'($urandom());
    r = $urandom_range(0, 99);
    if (r < 35) w.burst_time = TIME_W'($urandom_range(0, 7));
    else if (r < 45) w.burst_time = ($urandom_range(0, 1) != 0) ? TIME_MAX : '0;
    else w.burst_time = TIME_W'($urandom());
    return w;
  endfunction

  task automatic add_item(input req_word_t w, input bit drain);
    pending_t p;
    p.word = w;
    p.drain = drain;
    pending_words = {pending_words, p};
    case (w.req_type)
      REQ_CLEAR:  plan_cnt = 0;
      REQ_APPEND: if (plan_cnt < MAX_RECORDS) plan_cnt++;
      REQ_POP:    if (plan_cnt > 0) plan_cnt--;
      default:    ;
    endcase
  endtask

  // Appends, an optional sort, pops (possibly past empty), sometimes a clear, or noise
  task automatic add_sequence();
    int n, i;
    bit drain;
    drain = ($urandom_range(0, 99) < 5);
    if ($urandom_range(0, 99) < 70) begin
      n = $urandom_range(1, 8);
      for (i = 0; i < n; i++) add_item(rand_word(REQ_APPEND), drain && i == 0);
      if ($urandom_range(0, 99) < 80) add_item(rand_word(REQ_SORT), 1'b0);
      n = $urandom_range(0, n + 1);
      for (i = 0; i < n; i++) add_item(rand_word(REQ_POP), 1'b0);
      if ($urandom_range(0, 99) < 10) add_item(rand_word(REQ_CLEAR), 1'b0);
    end else begin
      add_item(rand_word(REQ_W'($urandom_range(0, 3))), drain);
    end
  endtask

  // Driver: present the oldest pending word, hold it while stalled
  always @(posedge clk) begin
    logic      nxt_valid;
    req_word_t nxt_req;
    if (rst) begin
      req_valid <= 1'b0;
      req <= '0;
    end else begin
      nxt_valid = req_valid;
      nxt_req = req;
      if (req_valid && !req_stall) begin
        expected_rsps = {expected_rsps, apply_request(req)};
        kind_cnt[req.req_type]++;
        void'(pending_words.pop_front());
        nxt_valid = 1'b0;
        send_gap = calm ? 0 : pick_idle();
      end
      if (!nxt_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_words.size() > 0 &&
                     (!pending_words[0].drain || expected_rsps.size() == 0)) begin
          nxt_valid = 1'b1;
          nxt_req = pending_words[0].word;
        end
      end
      req_valid <= nxt_valid;
      req <= nxt_req;
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // Monitor: compare each accepted response word with the oldest prediction
  always @(posedge clk) begin
    rsp_word_t e;
    int        n;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t: response with none expected, actual %h", $time, rsp);
          errors++;
        end else begin
          e = expected_rsps.pop_front();
          check_field("status", 32'(e.status), 32'(rsp.status));
          check_field("out_proc_id", 32'(e.out_proc_id), 32'(rsp.out_proc_id));
          check_field("out_arrival_time", 32'(e.out_arrival_time),
                      32'(rsp.out_arrival_time));
          check_field("out_burst_time", 32'(e.out_burst_time), 32'(rsp.out_burst_time));
          check_field("remaining", 32'(e.remaining), 32'(rsp.remaining));
          checked++;
          if (e.status == STATUS_FULL) dropped_cnt++;
          if (e.status == STATUS_EMPTY) empty_pop_cnt++;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_stall <= 1'b1;
      end else begin
        n = calm ? 0 : pick_idle();
        rsp_stall <= (n != 0);
        stall_left = (n > 0) ? n - 1 : 0;
      end
    end
  end

  // Cycle and idle counters
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  // Watchdog
  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int i, n_directed;
    // Directed: empty cases, extreme fields, ties in cpu time, clear in between
    add_item(rand_word(REQ_POP), 1'b0);
    add_item(rand_word(REQ_SORT), 1'b0);
    add_item('{REQ_CLEAR, 16'hFFFF, TIME_MAX, TIME_MAX}, 1'b0);
    add_item('{REQ_APPEND, 16'h0000, '0, TIME_MAX}, 1'b0);
    add_item('{REQ_SORT, 16'hFFFF, TIME_MAX, '0}, 1'b0);
    add_item('{REQ_APPEND, 16'hFFFF, TIME_MAX, '0}, 1'b0);
    add_item('{REQ_APPEND, 16'h1234, 31'd5, TIME_MAX}, 1'b0);
    add_item('{REQ_APPEND, 16'h5A5A, 31'h2AAA_AAAA, '0}, 1'b0);
    add_item('{REQ_APPEND, 16'hA5A5, 31'h5555_5555, 31'd100}, 1'b0);
    add_item(rand_word(REQ_SORT), 1'b0);
    for (i = 0; i < 6; i++) add_item(rand_word(REQ_POP), 1'b0);
    add_item(rand_word(REQ_APPEND), 1'b0);
    add_item(rand_word(REQ_APPEND), 1'b0);
    add_item(rand_word(REQ_CLEAR), 1'b0);
    add_item(rand_word(REQ_POP), 1'b0);
    add_item(rand_word(REQ_APPEND), 1'b0);
    add_item(rand_word(REQ_POP), 1'b0);
    n_directed = pending_words.size();

    // Random sequences, then a fill past full with the ring wrapped, then more
    while (pending_words.size() < n_directed + 30) add_sequence();
    add_item(rand_word(REQ_CLEAR), 1'b0);
    for (i = 0; i < 6; i++) add_item(rand_word(REQ_APPEND), 1'b0);
    for (i = 0; i < 3; i++) add_item(rand_word(REQ_POP), 1'b0);
    while (plan_cnt < MAX_RECORDS) add_item(rand_word(REQ_APPEND), 1'b0);
    add_item(rand_word(REQ_APPEND), 1'b0);
    add_item(rand_word(REQ_APPEND), 1'b0);
    add_item(rand_word(REQ_SORT), 1'b0);
    for (i = 0; i < $urandom_range(3, 8); i++) add_item(rand_word(REQ_POP), 1'b0);
    for (i = 0; i < 4; i++) add_item(rand_word(REQ_APPEND), 1'b0);
    add_item(rand_word(REQ_SORT), 1'b0);
    add_item(rand_word(REQ_POP), 1'b1);
    while (pending_words.size() < 140) add_sequence();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (pending_words.size() > 0 || req_valid || expected_rsps.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_rsps.size() != 0) begin
      $display("%0t: %0d responses never arrived", $time, expected_rsps.size());
      errors++;
    end

    $display("Requests: %0d clear, %0d append, %0d sort, %0d pop; %0d responses checked",
             kind_cnt[REQ_CLEAR], kind_cnt[REQ_APPEND], kind_cnt[REQ_SORT],
             kind_cnt[REQ_POP], checked);
    $display("Dropped appends on a full table: %0d, pops on an empty table: %0d",
             dropped_cnt, empty_pop_cnt);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
`default_nettype wire
